// ===== design/tirisc_pkg.sv =====
// Package for the tiny integer execute core: opcodes, field widths,
// register file port types and immediate helpers. No dependencies.
`default_nettype none

package tirisc_pkg;

    localparam int XLEN       = 32;
    localparam int NUM_REGS   = 32;
    localparam int RADDR_W    = 5;
    localparam int OPC_W      = 7;

    localparam logic [OPC_W-1:0] OP_ADD  = 7'd1;
    localparam logic [OPC_W-1:0] OP_ADDI = 7'd2;
    localparam logic [OPC_W-1:0] OP_BEQ  = 7'd3;
    localparam logic [OPC_W-1:0] OP_BLTU = 7'd4;
    localparam logic [OPC_W-1:0] OP_CALL = 7'd5;
    localparam logic [OPC_W-1:0] OP_J    = 7'd6;
    localparam logic [OPC_W-1:0] OP_LI   = 7'd7;
    localparam logic [OPC_W-1:0] OP_LUI  = 7'd8;
    localparam logic [OPC_W-1:0] OP_MV   = 7'd9;

    // registers reported by a call
    localparam logic [RADDR_W-1:0] REG_CALL_IDX = 5'd11;
    localparam logic [RADDR_W-1:0] REG_CALL_RES = 5'd12;
    localparam logic [RADDR_W-1:0] REG_ZERO     = 5'd0;

    localparam logic [XLEN-1:0] PC_STEP    = 32'd4;
    localparam logic [XLEN-1:0] UIMM_MASK  = 32'hffff_f000;

    typedef struct packed {
        logic               en;
        logic [RADDR_W-1:0] addr_a;
        logic [RADDR_W-1:0] addr_b;
    } rf_rd_t;

    typedef struct packed {
        logic               en;
        logic [RADDR_W-1:0] addr;
        logic [XLEN-1:0]    data;
    } rf_wr_t;

    function automatic logic [XLEN-1:0] sext_imm12(input logic [XLEN-1:0] w);
        return {{20{w[31]}}, w[31:20]};
    endfunction

    function automatic logic [XLEN-1:0] branch_offs(input logic [XLEN-1:0] w);
        return {{19{w[31]}}, w[31:20], 1'b0};
    endfunction

    function automatic logic [XLEN-1:0] jump_offs(input logic [XLEN-1:0] w);
        return {{11{w[31]}}, w[31:12], 1'b0};
    endfunction

endpackage

`default_nettype wire

// ===== design/tirisc_regfile.sv =====
// Register file: 32 x 32 synchronous memory, two registered read ports,
// one write port, per-entry valid bits and write-to-read forwarding.
// Depends on tirisc_pkg.
`default_nettype none

module tirisc_regfile (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire tirisc_pkg::rf_rd_t     rd_req,
    input  wire tirisc_pkg::rf_wr_t     wr_req,
    output logic [tirisc_pkg::XLEN-1:0] rd_data_a,
    output logic [tirisc_pkg::XLEN-1:0] rd_data_b
);

    logic [tirisc_pkg::XLEN-1:0]     rf_mem [tirisc_pkg::NUM_REGS];
    logic [tirisc_pkg::NUM_REGS-1:0] vld_reg;

    logic [tirisc_pkg::XLEN-1:0] mem_a_reg;
    logic [tirisc_pkg::XLEN-1:0] mem_b_reg;
    logic                        vld_a_reg;
    logic                        vld_b_reg;
    logic                        hit_a_reg;
    logic                        hit_b_reg;
    logic [tirisc_pkg::XLEN-1:0] fwd_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_req.en)
        begin
            vld_reg[wr_req.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_req.en)
        begin
            rf_mem[wr_req.addr] <= wr_req.data;
        end
        if (rd_req.en)
        begin
            mem_a_reg <= rf_mem[rd_req.addr_a];
            mem_b_reg <= rf_mem[rd_req.addr_b];
            vld_a_reg <= vld_reg[rd_req.addr_a];
            vld_b_reg <= vld_reg[rd_req.addr_b];
            // read in the same cycle as a write sees old data: catch it here
            hit_a_reg <= wr_req.en && (wr_req.addr == rd_req.addr_a);
            hit_b_reg <= wr_req.en && (wr_req.addr == rd_req.addr_b);
            fwd_reg   <= wr_req.data;
        end
    end

    always_comb
    begin
        if (hit_a_reg)
            rd_data_a = fwd_reg;
        else if (vld_a_reg)
            rd_data_a = mem_a_reg;
        else
            rd_data_a = '0;

        if (hit_b_reg)
            rd_data_b = fwd_reg;
        else if (vld_b_reg)
            rd_data_b = mem_b_reg;
        else
            rd_data_b = '0;
    end

endmodule

`default_nettype wire

// ===== design/tiny_risc_instruction_execute_core.sv =====
// Top level of the tiny integer execute core: read stage, execute stage and
// output register around the register file. Depends on tirisc_pkg and
// tirisc_regfile.
`default_nettype none

// One instruction word goes in per input beat and one result beat comes out
// for it. The core sustains one beat per clock unless out_stall holds the
// output register: an instruction is accepted in the read stage, where its
// two register-file reads are issued on the accepting edge, and is executed
// in the following cycle, when the read data arrives from the memory; the
// result lands in the output register when the execute stage advances. The
// read stage is there because register file memory reads are registered.
// Each instruction needs at most two register reads (rs1/rs2, rd/rs1 for
// branches, or registers 11 and 12 for a call), chosen from the opcode as
// the word arrives. A write by the instruction in the execute stage is
// forwarded to a read issued in the same cycle, so back-to-back dependent
// instructions see each other's results. Registers reset to zero through
// per-entry valid bits; there is no clearing pass. After reset the
// program counter behind fetch_addr starts at zero; once an illegal
// opcode retires, halted stays high, the fetch address freezes and later
// instructions are consumed without effect. in_stall rises only while the
// execute stage holds a result that the output register cannot take.

module tiny_risc_instruction_execute_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] instr_word,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      fetch_addr,
    output logic             halted,
    output logic             call_event,
    output logic [31:0]      call_index_value,
    output logic [31:0]      call_result_value
);

    localparam int XLEN    = tirisc_pkg::XLEN;
    localparam int OPC_W   = tirisc_pkg::OPC_W;
    localparam int RADDR_W = tirisc_pkg::RADDR_W;

    logic in_accept;
    logic s1_go;

    // read stage decode
    logic [OPC_W-1:0]   in_opc;
    tirisc_pkg::rf_rd_t rd_req;
    tirisc_pkg::rf_wr_t wr_req;

    logic [XLEN-1:0] op_a;
    logic [XLEN-1:0] op_b;

    // execute stage
    logic            s1_valid_reg;
    logic [XLEN-1:0] s1_instr_reg;

    logic [OPC_W-1:0]   s1_opc;
    logic [RADDR_W-1:0] s1_rd;

    // architectural state outside the register file
    logic [XLEN-1:0] pc_reg;
    logic [XLEN-1:0] pc_next;
    logic            halt_reg;
    logic            halt_next;

    logic            wr_want;
    logic [XLEN-1:0] wr_data;
    logic            call_hit;
    logic [XLEN-1:0] pc_inc;
    logic [XLEN-1:0] pc_br;
    logic [XLEN-1:0] pc_jmp;

    // output register
    logic            out_valid_reg;
    logic [XLEN-1:0] out_fetch_reg;
    logic            out_halted_reg;
    logic            out_call_reg;
    logic [XLEN-1:0] out_cidx_reg;
    logic [XLEN-1:0] out_cres_reg;

    assign s1_go     = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !s1_go;
    assign in_accept = in_valid && !in_stall;

    // pick the two read addresses from the incoming opcode
    assign in_opc = instr_word[6:0];

    always_comb
    begin
        rd_req.en = in_accept;
        unique case (in_opc) inside
            tirisc_pkg::OP_BEQ, tirisc_pkg::OP_BLTU:
            begin
                rd_req.addr_a = instr_word[11:7];
                rd_req.addr_b = instr_word[16:12];
            end
            tirisc_pkg::OP_CALL:
            begin
                rd_req.addr_a = tirisc_pkg::REG_CALL_IDX;
                rd_req.addr_b = tirisc_pkg::REG_CALL_RES;
            end
            default:
            begin
                rd_req.addr_a = instr_word[16:12];
                rd_req.addr_b = instr_word[21:17];
            end
        endcase
    end

    tirisc_regfile u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_req    (rd_req),
        .wr_req    (wr_req),
        .rd_data_a (op_a),
        .rd_data_b (op_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_instr_reg <= instr_word;
        end
    end

    // execute
    assign s1_opc = s1_instr_reg[6:0];
    assign s1_rd  = s1_instr_reg[11:7];
    assign pc_inc = pc_reg + tirisc_pkg::PC_STEP;
    assign pc_br  = pc_reg + tirisc_pkg::branch_offs(s1_instr_reg);
    assign pc_jmp = pc_reg + tirisc_pkg::jump_offs(s1_instr_reg);

    always_comb
    begin
        pc_next   = pc_inc;
        halt_next = 1'b0;
        wr_want   = 1'b0;
        wr_data   = op_a;
        call_hit  = 1'b0;
        unique case (s1_opc)
            tirisc_pkg::OP_ADD:
            begin
                wr_want = 1'b1;
                wr_data = op_a + op_b;
            end
            tirisc_pkg::OP_ADDI:
            begin
                wr_want = 1'b1;
                wr_data = op_a + tirisc_pkg::sext_imm12(s1_instr_reg);
            end
            tirisc_pkg::OP_BEQ:
            begin
                if (op_a == op_b)
                    pc_next = pc_br;
            end
            tirisc_pkg::OP_BLTU:
            begin
                if (op_a < op_b)
                    pc_next = pc_br;
            end
            tirisc_pkg::OP_CALL:
            begin
                call_hit = 1'b1;
            end
            tirisc_pkg::OP_J:
            begin
                pc_next = pc_jmp;
            end
            tirisc_pkg::OP_LI:
            begin
                wr_want = 1'b1;
                wr_data = tirisc_pkg::sext_imm12(s1_instr_reg);
            end
            tirisc_pkg::OP_LUI:
            begin
                wr_want = 1'b1;
                wr_data = s1_instr_reg & tirisc_pkg::UIMM_MASK;
            end
            tirisc_pkg::OP_MV:
            begin
                wr_want = 1'b1;
                wr_data = op_a;
            end
            default:
            begin
                halt_next = 1'b1;
            end
        endcase
    end

    // writes to register zero are dropped; nothing retires once halted
    always_comb
    begin
        wr_req.en   = s1_go && !halt_reg && wr_want && (s1_rd != tirisc_pkg::REG_ZERO);
        wr_req.addr = s1_rd;
        wr_req.data = wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= '0;
            halt_reg <= 1'b0;
        end
        else if (s1_go && !halt_reg)
        begin
            pc_reg   <= pc_next;
            halt_reg <= halt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go)
        begin
            if (halt_reg)
            begin
                out_fetch_reg  <= pc_reg;
                out_halted_reg <= 1'b1;
                out_call_reg   <= 1'b0;
                out_cidx_reg   <= '0;
                out_cres_reg   <= '0;
            end
            else
            begin
                out_fetch_reg  <= pc_next;
                out_halted_reg <= halt_next;
                out_call_reg   <= call_hit;
                out_cidx_reg   <= call_hit ? op_a : '0;
                out_cres_reg   <= call_hit ? op_b : '0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign fetch_addr        = out_fetch_reg;
    assign halted            = out_halted_reg;
    assign call_event        = out_call_reg;
    assign call_index_value  = out_cidx_reg;
    assign call_result_value = out_cres_reg;

endmodule

`default_nettype wire

// ===== design/tirisc_checker.sv =====
// Port-level checker for the tiny integer execute core, with its bind.
// Depends on tiny_risc_instruction_execute_core's port list only.
`default_nettype none

module tirisc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [31:0] fetch_addr,
    input wire logic        halted,
    input wire logic        call_event,
    input wire logic [31:0] call_index_value,
    input wire logic [31:0] call_result_value
);

    logic        out_beat;
    logic        seen_halt_reg;
    logic [31:0] last_fa_reg;

    assign out_beat = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_halt_reg <= 1'b0;
            last_fa_reg   <= '0;
        end
        else if (out_beat)
        begin
            seen_halt_reg <= seen_halt_reg || halted;
            last_fa_reg   <= fetch_addr;
        end
    end

    // halt is sticky across delivered beats
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> halted)
        else $error("halted dropped after a halted beat");

    // once halted the fetch address freezes
    a_pc_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && seen_halt_reg |-> fetch_addr == last_fa_reg)
        else $error("fetch address moved while halted");

    a_call_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !call_event |-> call_index_value == 32'd0 && call_result_value == 32'd0)
        else $error("call fields nonzero without a call");

    a_halt_no_call: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halted |-> !call_event)
        else $error("call reported on a halted beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fetch_addr) && $stable(halted))
        else $error("stalled result beat changed");

endmodule

bind tiny_risc_instruction_execute_core tirisc_checker u_checker (.*);

`default_nettype wire
